/* src/sha1sh_pkg.sv */
// shared types and constants of the sha-1 stream hasher
`default_nettype none
package sha1sh_pkg;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} digest_t;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} qent_t;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage
`default_nettype wire

/* src/sha1sh_front.sv */
// front stage: registers incoming transactions and classifies them into queue entries
`default_nettype none
module sha1sh_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_valid,
	output logic             cmd_stall,
	input  sha1sh_pkg::cmd_t cmd,
	output logic             push_valid,
	input  wire              push_ready,
	output sha1sh_pkg::qent_t push_data
);
	import sha1sh_pkg::*;

	logic  vld_s1;
	qent_t ent_s1;

	assign cmd_stall  = vld_s1 && !push_ready;
	assign push_valid = vld_s1;
	assign push_data  = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			ent_s1.op   <= cmd.command ? OP_FINISH : OP_ABSORB;
			ent_s1.data <= cmd.data_byte;
		end
	end

endmodule
`default_nettype wire

/* src/sha1sh_queue.sv */
// small fifo between the front stage and the hash core
`default_nettype none
module sha1sh_queue #(
	parameter int DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push_valid,
	output logic              push_ready,
	input  sha1sh_pkg::qent_t push_data,
	output logic              pop_valid,
	input  wire               pop_ready,
	output sha1sh_pkg::qent_t pop_data
);
	import sha1sh_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* src/sha1sh_core.sv */
// hash core: block buffer, padding sequencer, round unit and digest output register
`default_nettype none
module sha1sh_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 pop_valid,
	output logic                pop_ready,
	input  sha1sh_pkg::qent_t   pop_data,
	output logic                digest_valid,
	input  wire                 digest_stall,
	output sha1sh_pkg::digest_t digest
);
	import sha1sh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t           state_q;
	state_t           ret_q;
	logic [5:0]       pos_q;
	logic [60:0]      nbytes_q;
	logic [2:0]       len_idx_q;
	logic [6:0]       rnd_q;
	logic [2:0]       word_q;
	logic [4:0][31:0] h_q;
	logic             dv_q;
	digest_t          dout_q;

	logic [511:0]     blk_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;

	logic             sh_en;
	logic [7:0]       sh_byte;
	state_t           sh_next;
	logic             blk_full;
	logic [63:0]      len_w;
	logic [31:0]      w0, w2, w8, w13, w_new;
	logic [31:0]      f_w, k_w, tmp_w;
	logic             out_load;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	assign pop_ready = (state_q == ST_IDLE);
	assign blk_full  = sh_en && (pos_q == 6'd63);
	assign len_w     = {nbytes_q, 3'b000} << {len_idx_q, 3'b000};
	assign out_load  = (state_q == ST_OUT) && (!dv_q || !digest_stall);

	always_comb begin
		sh_en   = 1'b0;
		sh_byte = 8'h00;
		sh_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					sh_en = 1'b1;
					if (pop_data.op == OP_FINISH) begin
						sh_byte = PAD_BYTE;
						sh_next = ST_PAD;
					end else begin
						sh_byte = pop_data.data;
						sh_next = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				if (pos_q != 6'd56) begin
					sh_en   = 1'b1;
					sh_byte = 8'h00;
					sh_next = ST_PAD;
				end
			end
			ST_LEN: begin
				sh_en   = 1'b1;
				sh_byte = len_w[63:56];
				sh_next = (len_idx_q == 3'd7) ? ST_OUT : ST_LEN;
			end
			ST_ROUND, ST_ADD, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// message schedule window and round function
	assign w0    = blk_q[511:480];
	assign w2    = blk_q[447:416];
	assign w8    = blk_q[255:224];
	assign w13   = blk_q[95:64];
	assign w_new = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_w = (b_q & c_q) | (~b_q & d_q);
			k_w = K_0;
		end else if (rnd_q < 7'd40) begin
			f_w = b_q ^ c_q ^ d_q;
			k_w = K_1;
		end else if (rnd_q < 7'd60) begin
			f_w = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_w = K_2;
		end else begin
			f_w = b_q ^ c_q ^ d_q;
			k_w = K_3;
		end
	end

	assign tmp_w = rotl(a_q, 5) + f_w + e_q + w0 + k_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			pos_q     <= '0;
			nbytes_q  <= '0;
			len_idx_q <= '0;
			rnd_q     <= '0;
			word_q    <= '0;
			h_q       <= H_INIT;
			dv_q      <= 1'b0;
			dout_q    <= '0;
		end else begin
			if (dv_q && !digest_stall) begin
				dv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid && pop_data.op == OP_ABSORB) begin
						nbytes_q <= nbytes_q + 61'd1;
					end
				end
				ST_PAD: begin
					if (pos_q == 6'd56) begin
						len_idx_q <= '0;
						state_q   <= ST_LEN;
					end
				end
				ST_LEN: begin
					len_idx_q <= len_idx_q + 3'd1;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0]  <= h_q[0] + a_q;
					h_q[1]  <= h_q[1] + b_q;
					h_q[2]  <= h_q[2] + c_q;
					h_q[3]  <= h_q[3] + d_q;
					h_q[4]  <= h_q[4] + e_q;
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (out_load) begin
						dv_q               <= 1'b1;
						dout_q.digest_word <= h_q[word_q];
						dout_q.last_word   <= (word_q == 3'd4);
						if (word_q == 3'd4) begin
							word_q   <= '0;
							h_q      <= H_INIT;
							nbytes_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							word_q <= word_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (sh_en) begin
				pos_q <= pos_q + 6'd1;
				if (blk_full) begin
					rnd_q   <= '0;
					ret_q   <= sh_next;
					state_q <= ST_ROUND;
				end else begin
					state_q <= sh_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sh_en) begin
			blk_q <= {blk_q[503:0], sh_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (blk_full) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= tmp_w;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign digest_valid = dv_q;
	assign digest       = dout_q;

endmodule
`default_nettype wire

/* src/sha1_stream_hasher_top.sv */
// top level of the sha-1 stream hasher
// Computes SHA-1 over a byte stream. A transaction with command 0 absorbs data_byte; a
// transaction with command 1 pads the message, appends the 64-bit bit length and then
// returns the digest as five 32-bit words, H0 first, last_word set on H4, after which the
// hasher is back in its initial state. The core takes an absorbed byte while it is idle;
// every 64th byte starts a block compression (80 rounds at one round per cycle in the
// single round unit, then the chaining-word add), during which it takes no transactions.
// A finish shifts in the padding bytes, then, after a turnaround state, the eight length
// bytes, with one or two compressions on the way, then outputs the five digest words,
// holding each while digest_stall is set. The front register and the transaction queue
// let the source keep sending while a block is being compressed, until the queue fills.
`default_nettype none
module sha1_stream_hasher_top #(
	parameter int QUEUE_DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_stall,
	input  sha1sh_pkg::cmd_t    cmd,
	output logic                digest_valid,
	input  wire                 digest_stall,
	output sha1sh_pkg::digest_t digest
);
	import sha1sh_pkg::*;

	logic  push_valid;
	logic  push_ready;
	qent_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	qent_t pop_data;

	sha1sh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sha1sh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sha1sh_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

endmodule
`default_nettype wire

/* verif/sha1_stream_hasher_top_test.sv */
// self-checking testbench for the sha-1 stream hasher with a built-in digest predictor
module sha1_stream_hasher_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1sh_pkg::*;

	localparam int ITEM_TARGET    = 410;
	localparam int IDLE_LIMIT     = 3000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int PRINT_LIMIT    = 100;

	typedef struct {
		bit   drain;
		cmd_t c;
	} stim_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    cmd_valid    = 1'b0;
	cmd_t    cmd          = '0;
	logic    digest_stall = 1'b0;
	logic    cmd_stall;
	logic    digest_valid;
	digest_t digest;

	stim_t   pending[$];
	digest_t digest_q[$];
	int      item_total    = 0;
	int      mismatches    = 0;
	int      finishes_sent = 0;
	int      words_checked = 0;
	int      idle_cycles   = 0;

	// digest predictor state
	logic [31:0] chain_h[5];
	logic [7:0]  msg_block[64];
	int          fill_pos;
	logic [63:0] bit_count;

	sha1_stream_hasher_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.digest_valid(digest_valid),
		.digest_stall(digest_stall),
		.digest      (digest)
	);

	always #2 clk = ~clk;

	task automatic hasher_reset();
		for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
		for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
		fill_pos = 0;
		bit_count = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, k, x, sum;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 16) begin
				x = w[t];
			end else begin
				x = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
				x = {x[30:0], x[31]};
				w[t % 16] = x;
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = K_0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = K_1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_2;
			end else begin
				f = b ^ c ^ d;
				k = K_3;
			end
			sum = {a[26:0], a[31:27]} + f + e + x + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
		fill_pos = 0;
	endtask

	task automatic hash_absorb(input logic [7:0] data);
		msg_block[fill_pos] = data;
		fill_pos++;
		bit_count += 64'd8;
		if (fill_pos == 64) compress_block();
	endtask

	task automatic hash_finish();
		digest_t word;
		msg_block[fill_pos] = PAD_BYTE;
		fill_pos++;
		// no room left for the length: pad out and compress an extra block
		if (fill_pos > 56) begin
			while (fill_pos < 64) begin
				msg_block[fill_pos] = 8'h00;
				fill_pos++;
			end
			compress_block();
		end
		while (fill_pos < 56) begin
			msg_block[fill_pos] = 8'h00;
			fill_pos++;
		end
		for (int i = 0; i < 8; i++) msg_block[56 + i] = bit_count[63 - 8*i -: 8];
		compress_block();
		for (int i = 0; i < 5; i++) begin
			word.digest_word = chain_h[i];
			word.last_word   = (i == 4);
			digest_q.push_back(word);
		end
		hasher_reset();
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic push_byte(input logic [7:0] data);
		stim_t s;
		s.drain = 1'b0;
		s.c.command = OP_ABSORB;
		s.c.data_byte = data;
		pending.push_back(s);
		item_total++;
	endtask

	task automatic push_finish(input logic [7:0] junk);
		stim_t s;
		s.drain = 1'b0;
		s.c.command = OP_FINISH;
		s.c.data_byte = junk;
		pending.push_back(s);
		item_total++;
	endtask

	task automatic push_drain();
		stim_t s;
		s.drain = 1'b1;
		s.c = '0;
		pending.push_back(s);
	endtask

	task automatic add_message(input int len);
		for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
		push_finish(8'($urandom_range(0, 255)));
	endtask

	function automatic int pick_length();
		int edge_lens[9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		if ($urandom_range(0, 4) == 0) return edge_lens[$urandom_range(0, 8)];
		return $urandom_range(0, 40);
	endfunction

	// sender: bursts of transactions separated by random gaps
	always @(posedge clk or negedge arst_n) begin : driver
		int    gap_left;
		int    burst_left;
		int    fin_now;
		logic  next_valid;
		cmd_t  next_cmd;
		stim_t s;
		if (!arst_n) begin
			cmd_valid     <= 1'b0;
			cmd           <= '0;
			finishes_sent <= 0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			fin_now = finishes_sent;
			if (cmd_valid && !cmd_stall && cmd.command == OP_FINISH) fin_now++;
			next_valid = cmd_valid;
			next_cmd = cmd;
			if (!cmd_valid || !cmd_stall) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0) begin
					if (pending[0].drain) begin
						// hold off until every digest word is back
						if (words_checked >= 5 * fin_now) void'(pending.pop_front());
					end else begin
						s = pending.pop_front();
						next_valid = 1'b1;
						next_cmd = s.c;
						if (burst_left > 0) burst_left--;
						if (burst_left == 0) begin
							burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						end
					end
				end
			end
			cmd_valid     <= next_valid;
			cmd           <= next_cmd;
			finishes_sent <= fin_now;
		end
	end

	// receiver stall pattern, switching at random among no stall, random stall and stall bursts
	always @(posedge clk or negedge arst_n) begin : stall_gen
		int cyc;
		int mode;
		int hold;
		if (!arst_n) begin
			digest_stall <= 1'b0;
			cyc = 0;
			mode = 0;
			hold = 0;
		end else begin
			if (cyc % 128 == 0) mode = $urandom_range(0, 2);
			cyc++;
			case (mode)
				0: begin
					digest_stall <= 1'b0;
				end
				1: begin
					digest_stall <= ($urandom_range(0, 2) == 0);
				end
				default: begin
					if (hold > 0) begin
						hold--;
						digest_stall <= 1'b1;
					end else begin
						digest_stall <= 1'b0;
						if ($urandom_range(0, 3) == 0) hold = $urandom_range(1, 10);
					end
				end
			endcase
		end
	end

	// checks digest words, then feeds accepted commands to the predictor
	always @(posedge clk or negedge arst_n) begin : monitor
		digest_t want;
		if (!arst_n) begin
			hasher_reset();
			words_checked <= 0;
		end else begin
			if (digest_valid && !digest_stall) begin
				words_checked <= words_checked + 1;
				if (digest_q.size() == 0) begin
					flag_mismatch("unexpected digest word", digest.digest_word, '0);
				end else begin
					want = digest_q.pop_front();
					if (digest.digest_word !== want.digest_word)
						flag_mismatch("digest_word", digest.digest_word, want.digest_word);
					if (digest.last_word !== want.last_word)
						flag_mismatch("last_word", 32'(digest.last_word), 32'(want.last_word));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				if (cmd.command == OP_FINISH) hash_finish();
				else hash_absorb(cmd.data_byte);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (cmd_valid && !cmd_stall) || (digest_valid && !digest_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// empty message, then short known messages and back-to-back finishes
		push_finish(8'h00);
		push_byte(8'h61);
		push_byte(8'h62);
		push_byte(8'h63);
		push_finish(8'hFF);
		push_byte(8'hFF);
		push_finish(8'h5A);
		push_byte(8'h00);
		push_finish(8'hA5);
		push_finish(8'hFF);
		push_finish(8'h00);
		push_drain();

		// two-block padding and an exactly full block first
		add_message(56);
		add_message(64);
		while (item_total < ITEM_TARGET) begin
			add_message(pick_length());
			if ($urandom_range(0, 4) == 0) push_drain();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || cmd_valid) @(negedge clk);
		while (digest_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
src/sha1sh_pkg.sv
src/sha1sh_front.sv
src/sha1sh_queue.sv
src/sha1sh_core.sv
src/sha1_stream_hasher_top.sv
verif/sha1_stream_hasher_top_test.sv
